// ===== rtl/drt_pkg.sv =====
// shared types and command codes for the draw retirement tracker
package drt_pkg;

	typedef logic [2:0]  cmd_t;
	typedef logic [31:0] draw_id_t;

	localparam cmd_t CMD_SUBMIT   = 3'd0;
	localparam cmd_t CMD_FE_DONE  = 3'd1;
	localparam cmd_t CMD_PROGRESS = 3'd2;
	localparam cmd_t CMD_RETIRE   = 3'd3;
	localparam cmd_t CMD_BUSY     = 3'd4;

	localparam draw_id_t ID_MAX = 32'hFFFF_FFFF;

	localparam int WCNT_W = 4;
	localparam int WIDX_W = 3;

endpackage

// ===== rtl/draw_retirement_tracker.sv =====
// in-order retirement ring for in-flight draws
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+-----------------------------
//  command   | command, draw_id, worker_index, worker_front_pos,| transfer on start && !busy
//            | worker_back_pos, read_dependency, write_dependency|
//  result    | retired_upto, assigned_id, draw_retired,         | one-cycle strobe on done,
//            | resource_busy, id_exhausted                      | always taken
//  config    | cfg_wr_en, cfg_wr_data (worker_count)            | written when cfg_wr_en high
//
// submit, front end done, progress, busy query and unknown commands need no walk: the result
// strobes in the next cycle and busy never rises, so a new command can follow back to back.
// retire walks k slots, k = 0..RING_DEPTH-1: the slot id memory delivers
// one entry per cycle and all active workers are compared against it in parallel; busy is high
// while the walk runs. the result strobes in the cycle after the walk ends.
// reset clears all control state at once; the slot id memory needs no clearing pass.
// the receiver cannot stall, so nothing ever waits on the result side.
module draw_retirement_tracker #(
	parameter int RING_DEPTH  = 16,
	parameter int MAX_WORKERS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [drt_pkg::WCNT_W-1:0]  cfg_wr_data,
	input  logic                        start,
	output logic                        busy,
	input  drt_pkg::cmd_t               command,
	input  drt_pkg::draw_id_t           draw_id,
	input  logic [drt_pkg::WIDX_W-1:0]  worker_index,
	input  drt_pkg::draw_id_t           worker_front_pos,
	input  drt_pkg::draw_id_t           worker_back_pos,
	input  drt_pkg::draw_id_t           read_dependency,
	input  drt_pkg::draw_id_t           write_dependency,
	output logic                        done,
	output drt_pkg::draw_id_t           retired_upto,
	output drt_pkg::draw_id_t           assigned_id,
	output logic                        draw_retired,
	output logic                        resource_busy,
	output logic                        id_exhausted
);
	import drt_pkg::*;

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int WI_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

	// slot id memory, one read port with registered data
	draw_id_t slot_id_mem [RING_DEPTH];
	draw_id_t slot_id_s1;

	// per-slot flags live in flops so reset clears them at once
	logic [RING_DEPTH-1:0] in_use_q;
	logic [RING_DEPTH-1:0] fe_done_q;

	draw_id_t wfront_q [MAX_WORKERS];
	draw_id_t wback_q  [MAX_WORKERS];

	logic [WCNT_W-1:0] wcount_q;
	draw_id_t          last_ret_q;
	draw_id_t          next_q;
	logic [SLOT_W-1:0] tail_q;      // next_q mod RING_DEPTH
	logic [SLOT_W-1:0] head_q;      // (last_ret_q + 1) mod RING_DEPTH
	logic [SLOT_W-1:0] steps_q;
	logic              state_q;
	draw_id_t          chk_id_q;    // draw id kept for the retire check

	// result register
	logic     done_q;
	draw_id_t res_ret_q;
	draw_id_t res_asg_q;
	logic     res_rchk_q;
	logic     res_busy_q;
	logic     res_exh_q;

	logic accept;
	assign accept = start && (state_q == ST_IDLE);

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
		return (p == SLOT_LAST) ? '0 : p + 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// front end done: slot of draw_id found from its distance behind next_q.
	// only the last RING_DEPTH submitted ids can still sit in their slot
	// ---------------------------------------------------------------
	draw_id_t          fe_diff;
	logic [SLOT_W:0]   fe_dist;
	logic [SLOT_W:0]   fe_tail_x;
	logic [SLOT_W:0]   fe_slot_x;
	logic [SLOT_W-1:0] fe_slot;
	logic              fe_window;

	always_comb begin
		fe_diff   = next_q - draw_id;
		fe_dist   = fe_diff[SLOT_W:0];
		fe_tail_x = {1'b0, tail_q};
		fe_window = (draw_id != '0) && (draw_id < next_q) &&
			(fe_diff <= 32'(RING_DEPTH));
		if (fe_tail_x >= fe_dist) begin
			fe_slot_x = fe_tail_x - fe_dist;
		end else begin
			fe_slot_x = fe_tail_x + (SLOT_W+1)'(RING_DEPTH) - fe_dist;
		end
		fe_slot = fe_slot_x[SLOT_W-1:0];
	end

	// ---------------------------------------------------------------
	// retire start: forced retirement of draws older than the ring
	// ---------------------------------------------------------------
	draw_id_t          start_ret;
	logic [SLOT_W-1:0] start_head;
	logic              start_stop;

	always_comb begin
		start_ret  = last_ret_q;
		start_head = head_q;
		if ((next_q >= 32'(RING_DEPTH)) && (next_q - 32'(RING_DEPTH) > last_ret_q)) begin
			start_ret  = next_q - 32'(RING_DEPTH);
			start_head = slot_inc(tail_q);
		end
		start_stop = (last_ret_q == next_q) || (start_ret == ID_MAX) ||
			(start_head == tail_q);
	end

	// ---------------------------------------------------------------
	// walk step: is the slot at head_q still busy
	// ---------------------------------------------------------------
	logic              worker_behind;
	logic              slot_busy;
	logic              step_stop;
	logic [SLOT_W-1:0] step_head;
	draw_id_t          step_ret;

	always_comb begin
		worker_behind = 1'b0;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			if ((32'(i) < 32'(wcount_q)) &&
				((wfront_q[i] <= slot_id_s1) || (wback_q[i] <= slot_id_s1))) begin
				worker_behind = 1'b1;
			end
		end
		slot_busy = fe_done_q[head_q] ? worker_behind : in_use_q[head_q];
		step_head = slot_inc(head_q);
		step_ret  = last_ret_q + 1'b1;
		step_stop = slot_busy || (step_head == tail_q) || (steps_q == SLOT_LAST);
	end

	// read address for the slot id memory
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = step_head;
		if (accept && (command == CMD_RETIRE) && !start_stop) begin
			rd_en   = 1'b1;
			rd_addr = start_head;
		end else if ((state_q == ST_WALK) && !step_stop) begin
			rd_en   = 1'b1;
			rd_addr = step_head;
		end
	end

	logic sub_ok;
	assign sub_ok = accept && (command == CMD_SUBMIT) && (next_q != ID_MAX);

	always_ff @(posedge clk) begin
		if (sub_ok) begin
			slot_id_mem[tail_q] <= next_q;
		end
		if (rd_en) begin
			slot_id_s1 <= slot_id_mem[rd_addr];
		end
	end

	// ---------------------------------------------------------------
	// control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q   <= WCNT_W'(1);
			in_use_q   <= '0;
			fe_done_q  <= '0;
			last_ret_q <= '0;
			next_q     <= 32'd1;
			tail_q     <= SLOT_W'(1);
			head_q     <= SLOT_W'(1);
			steps_q    <= '0;
			state_q    <= ST_IDLE;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				wfront_q[i] <= '0;
				wback_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				wcount_q <= cfg_wr_data;
			end
			if (accept) begin
				case (command)
					CMD_SUBMIT: begin
						if (next_q != ID_MAX) begin
							in_use_q[tail_q]  <= 1'b1;
							fe_done_q[tail_q] <= 1'b0;
							next_q            <= next_q + 1'b1;
							tail_q            <= slot_inc(tail_q);
						end
					end
					CMD_FE_DONE: begin
						if (fe_window && in_use_q[fe_slot]) begin
							fe_done_q[fe_slot] <= 1'b1;
						end
					end
					CMD_PROGRESS: begin
						if (32'(worker_index) < 32'(MAX_WORKERS)) begin
							wfront_q[WI_W'(worker_index)] <= worker_front_pos;
							wback_q[WI_W'(worker_index)]  <= worker_back_pos;
						end
					end
					CMD_RETIRE: begin
						last_ret_q <= start_ret;
						head_q     <= start_head;
						steps_q    <= '0;
						if (!start_stop) begin
							state_q <= ST_WALK;
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_WALK) begin
				if (!slot_busy) begin
					if (fe_done_q[head_q]) begin
						in_use_q[head_q] <= 1'b0;
					end
					last_ret_q <= step_ret;
					head_q     <= step_head;
					steps_q    <= steps_q + 1'b1;
				end
				if (step_stop) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	logic res_load;
	assign res_load = (accept && ((command != CMD_RETIRE) || start_stop)) ||
		((state_q == ST_WALK) && step_stop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_load;
		end
	end

	draw_id_t dep_max;
	assign dep_max = (read_dependency > write_dependency) ? read_dependency : write_dependency;

	always_ff @(posedge clk) begin
		if (accept) begin
			chk_id_q <= draw_id;
		end
		if (accept) begin
			res_ret_q  <= last_ret_q;
			res_asg_q  <= '0;
			res_rchk_q <= 1'b0;
			res_busy_q <= 1'b0;
			res_exh_q  <= 1'b0;
			case (command)
				CMD_SUBMIT: begin
					if (next_q == ID_MAX) begin
						res_exh_q <= 1'b1;
					end else begin
						res_asg_q <= next_q;
					end
				end
				CMD_RETIRE: begin
					res_ret_q  <= start_ret;
					res_rchk_q <= (draw_id <= start_ret);
				end
				CMD_BUSY: begin
					res_busy_q <= (dep_max > last_ret_q);
				end
				default: ;
			endcase
		end else if (state_q == ST_WALK) begin
			res_asg_q  <= '0;
			res_busy_q <= 1'b0;
			res_exh_q  <= 1'b0;
			if (slot_busy) begin
				res_ret_q  <= last_ret_q;
				res_rchk_q <= (chk_id_q <= last_ret_q);
			end else begin
				res_ret_q  <= step_ret;
				res_rchk_q <= (chk_id_q <= step_ret);
			end
		end
	end

	assign busy          = (state_q == ST_WALK);
	assign done          = done_q;
	assign retired_upto  = res_ret_q;
	assign assigned_id   = res_asg_q;
	assign draw_retired  = res_rchk_q;
	assign resource_busy = res_busy_q;
	assign id_exhausted  = res_exh_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_retired_below_next: assert property (@(posedge clk) disable iff (!arst_n)
		last_ret_q < next_q)
		else $error("last retired id reached next draw id");

	a_retired_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (last_ret_q >= $past(last_ret_q)))
		else $error("last retired id moved backward");

	a_short_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command != CMD_RETIRE)) |=> done_q)
		else $error("single-cycle command gave no result");

	a_walk_not_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (head_q != tail_q))
		else $error("retire walk reached the submit slot");

	a_no_result_while_walking: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && !step_stop) |=> !done_q)
		else $error("result strobed in the middle of a retire walk");

endmodule

// ===== tb/sv/draw_retirement_tracker_tb.sv =====
// self-checking testbench for the draw retirement tracker: directed table, then random traffic
module draw_retirement_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drt_pkg::*;

	localparam int RING  = 16;
	localparam int NWORK = 8;

	// command codes the block decodes as no-ops
	localparam cmd_t CMD_RSVD5 = 3'd5;
	localparam cmd_t CMD_RSVD6 = 3'd6;
	localparam cmd_t CMD_RSVD7 = 3'd7;

	// one command transfer as seen on the input ports
	typedef struct packed {
		cmd_t     cmd;
		draw_id_t id;
		logic [2:0] widx;
		draw_id_t fpos;
		draw_id_t bpos;
		draw_id_t rdep;
		draw_id_t wdep;
	} cmd_item_t;

	// one result transfer
	typedef struct packed {
		draw_id_t retired_upto;
		draw_id_t assigned_id;
		logic     draw_retired;
		logic     resource_busy;
		logic     id_exhausted;
	} tracker_result_t;

	// directed row: command, whether the result is typed in, and the typed result
	typedef struct packed {
		cmd_item_t       item;
		logic            typed;
		tracker_result_t res;
	} dir_row_t;

	localparam int NDIR = 22;

	// rows with typed = 0 are checked against the predictor
	dir_row_t dir_rows [NDIR] = '{
		// idle block: nothing in flight, nothing busy
		'{'{CMD_BUSY, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
		'{'{CMD_RETIRE, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 1'b1, 1'b0, 1'b0}},
		// first two draws get ids 1 and 2
		'{'{CMD_SUBMIT, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h1, 1'b0, 1'b0, 1'b0}},
		'{'{CMD_SUBMIT, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h2, 1'b0, 1'b0, 1'b0}},
		'{'{CMD_BUSY, 32'h0, 3'd0, 32'h0, 32'h0, 32'h1, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 1'b0, 1'b1, 1'b0}},
		// draw 1 still has its front end running
		'{'{CMD_RETIRE, 32'h1, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
		// front end done on an unused slot, a live draw, an alias not yet issued and the top id
		'{'{CMD_FE_DONE, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{CMD_FE_DONE, 32'h1, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{CMD_FE_DONE, 32'h21, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{CMD_FE_DONE, 32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{CMD_PROGRESS, 32'h0, 3'd0, 32'h5, 32'h5, 32'h0, 32'h0}, 1'b0, '0},
		// worker 0 is past draw 1, so it retires and the walk stops at draw 2
		'{'{CMD_RETIRE, 32'h1, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h1, 32'h0, 1'b1, 1'b0, 1'b0}},
		// unused command codes only report the retire point
		'{'{CMD_RSVD5, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h1, 32'h0, 1'b0, 1'b0, 1'b0}},
		'{'{CMD_RSVD6, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h1, 32'h0, 1'b0, 1'b0, 1'b0}},
		'{'{CMD_RSVD7, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF}, 1'b1, '{32'h1, 32'h0, 1'b0, 1'b0, 1'b0}},
		// either dependency at the top id keeps the resource busy
		'{'{CMD_BUSY, 32'h0, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1,
			'{32'h1, 32'h0, 1'b0, 1'b1, 1'b0}},
		'{'{CMD_BUSY, 32'h0, 3'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
			'{32'h1, 32'h0, 1'b0, 1'b1, 1'b0}},
		'{'{CMD_RETIRE, 32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h1, 32'h0, 1'b0, 1'b0, 1'b0}},
		// progress on the last worker, outside the active set
		'{'{CMD_PROGRESS, 32'h0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b0, '0},
		'{'{CMD_FE_DONE, 32'h2, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		// draw 2 retires and the walk reaches the ring tail
		'{'{CMD_RETIRE, 32'h2, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h2, 32'h0, 1'b1, 1'b0, 1'b0}},
		'{'{CMD_BUSY, 32'h0, 3'd0, 32'h0, 32'h0, 32'h2, 32'h2}, 1'b1,
			'{32'h2, 32'h0, 1'b0, 1'b0, 1'b0}}
	};

	// worker count settings, one per random phase; 0 and 15 are the extremes
	localparam int NPHASE = 8;
	localparam logic [3:0] wc_plan [NPHASE] = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd9, 4'd1, 4'd2, 4'd7};
	localparam int PHASE_ITEMS = 130;

	// ports
	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	logic [3:0]      cfg_wr_data = 4'd0;
	logic            start = 1'b0;
	logic            busy;
	cmd_t            command = CMD_SUBMIT;
	draw_id_t        draw_id = '0;
	logic [2:0]      worker_index = '0;
	draw_id_t        worker_front_pos = '0;
	draw_id_t        worker_back_pos = '0;
	draw_id_t        read_dependency = '0;
	draw_id_t        write_dependency = '0;
	logic            done;
	draw_id_t        retired_upto;
	draw_id_t        assigned_id;
	logic            draw_retired;
	logic            resource_busy;
	logic            id_exhausted;

	// typed expectation travelling with the command of a directed row
	logic            row_typed = 1'b0;
	tracker_result_t row_res = '0;

	// predictor state
	draw_id_t        ring_id [RING];
	bit              ring_live [RING];
	bit              ring_fe_done [RING];
	draw_id_t        wk_front [NWORK];
	draw_id_t        wk_back [NWORK];
	draw_id_t        retired_id;
	draw_id_t        issue_id;
	logic [3:0]      active_workers;

	tracker_result_t pending_results [$];
	int              mismatches = 0;
	int              calm_left = 0;

	draw_retirement_tracker #(
		.RING_DEPTH (RING),
		.MAX_WORKERS(NWORK)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.draw_id         (draw_id),
		.worker_index    (worker_index),
		.worker_front_pos(worker_front_pos),
		.worker_back_pos (worker_back_pos),
		.read_dependency (read_dependency),
		.write_dependency(write_dependency),
		.done            (done),
		.retired_upto    (retired_upto),
		.assigned_id     (assigned_id),
		.draw_retired    (draw_retired),
		.resource_busy   (resource_busy),
		.id_exhausted    (id_exhausted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// a draw blocks retirement while its front end runs or any active worker lags it
	function automatic bit slot_blocked(int unsigned s);
		int unsigned n;
		if (!ring_fe_done[s])
			return ring_live[s];
		n = (active_workers > NWORK) ? NWORK : active_workers;
		for (int unsigned i = 0; i < n; i++) begin
			if (wk_front[i] <= ring_id[s] || wk_back[i] <= ring_id[s])
				return 1'b1;
		end
		ring_live[s] = 1'b0;
		return 1'b0;
	endfunction

	// one retire pass: force out draws that fell off the ring, then walk from the oldest
	function automatic void walk_retire();
		int unsigned head;
		int unsigned tail;
		if (retired_id == issue_id)
			return;
		if (issue_id >= 32'(RING) && issue_id - 32'(RING) > retired_id)
			retired_id = issue_id - 32'(RING);
		if (retired_id == ID_MAX)
			return;
		head = (retired_id + 32'd1) % RING;
		tail = issue_id % RING;
		for (int steps = 0; steps < RING; steps++) begin
			if (head == tail || slot_blocked(head))
				break;
			retired_id = retired_id + 32'd1;
			head = (head + 1) % RING;
		end
	endfunction

	// updates the tracked state for one command and returns its result
	function automatic tracker_result_t apply_command(cmd_item_t it);
		tracker_result_t r;
		int unsigned s;
		draw_id_t dep;
		r = '0;
		case (it.cmd)
			CMD_SUBMIT: begin
				if (issue_id == ID_MAX) begin
					r.id_exhausted = 1'b1;
				end else begin
					s = issue_id % RING;
					ring_id[s] = issue_id;
					ring_live[s] = 1'b1;
					ring_fe_done[s] = 1'b0;
					r.assigned_id = issue_id;
					issue_id = issue_id + 32'd1;
				end
			end
			CMD_FE_DONE: begin
				s = it.id % RING;
				if (ring_live[s] && ring_id[s] == it.id)
					ring_fe_done[s] = 1'b1;
			end
			CMD_PROGRESS: begin
				if (it.widx < NWORK) begin
					wk_front[it.widx] = it.fpos;
					wk_back[it.widx] = it.bpos;
				end
			end
			CMD_RETIRE: begin
				walk_retire();
				r.draw_retired = (it.id <= retired_id);
			end
			CMD_BUSY: begin
				dep = (it.rdep > it.wdep) ? it.rdep : it.wdep;
				r.resource_busy = (dep > retired_id);
			end
			default: begin
			end
		endcase
		r.retired_upto = retired_id;
		return r;
	endfunction

	// mostly well-formed traffic around the live window, some pure noise
	function automatic cmd_item_t random_command();
		cmd_item_t it;
		int unsigned pick;
		it.cmd  = CMD_RSVD7;
		it.id   = $urandom;
		it.widx = 3'($urandom);
		it.fpos = $urandom;
		it.bpos = $urandom;
		it.rdep = $urandom;
		it.wdep = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.cmd = CMD_SUBMIT;
		end else if (pick < 50) begin
			// mostly draws still in the ring, now and then one already gone
			it.cmd = CMD_FE_DONE;
			it.id = issue_id - 32'd1 - 32'($urandom_range(0, 17));
		end else if (pick < 70) begin
			it.cmd = CMD_PROGRESS;
			if ($urandom_range(0, 9) != 0) begin
				it.fpos = issue_id + 32'($urandom_range(0, 4)) - 32'd3;
				it.bpos = issue_id + 32'($urandom_range(0, 4)) - 32'd3;
			end
		end else if (pick < 85) begin
			it.cmd = CMD_RETIRE;
			if ($urandom_range(0, 7) != 0)
				it.id = retired_id + 32'($urandom_range(0, 6)) - 32'd3;
		end else if (pick < 93) begin
			it.cmd = CMD_BUSY;
			if ($urandom_range(0, 5) != 0) begin
				it.rdep = retired_id + 32'($urandom_range(0, 4)) - 32'd2;
				it.wdep = retired_id + 32'($urandom_range(0, 4)) - 32'd2;
			end
		end else begin
			it.cmd = cmd_t'($urandom_range(0, 7));
		end
		return it;
	endfunction

	// checker and predictor, both on the sampled port values of each rising edge
	always @(posedge clk) begin
		tracker_result_t want;
		tracker_result_t got;
		tracker_result_t pred;
		if (arst_n) begin
			// a result transfer is always taken; it must match the oldest expectation
			if (done) begin
				got = '{retired_upto, assigned_id, draw_retired, resource_busy, id_exhausted};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing pending: %h %h %b %b %b",
							$time, got.retired_upto, got.assigned_id, got.draw_retired,
							got.resource_busy, got.id_exhausted);
				end else begin
					want = pending_results.pop_front();
					if (got.retired_upto !== want.retired_upto ||
					    got.assigned_id !== want.assigned_id ||
					    got.draw_retired !== want.draw_retired ||
					    got.resource_busy !== want.resource_busy ||
					    got.id_exhausted !== want.id_exhausted) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected %h %h %b %b %b, got %h %h %b %b %b",
								$time, want.retired_upto, want.assigned_id, want.draw_retired,
								want.resource_busy, want.id_exhausted, got.retired_upto,
								got.assigned_id, got.draw_retired, got.resource_busy,
								got.id_exhausted);
					end
				end
			end
			// worker count write, only ever done while the block is idle
			if (cfg_wr_en)
				active_workers = cfg_wr_data;
			// command transfer: predict now, typed rows replace the predicted result
			if (start && !busy) begin
				pred = apply_command('{command, draw_id, worker_index, worker_front_pos,
					worker_back_pos, read_dependency, write_dependency});
				pending_results.insert(pending_results.size(), row_typed ? row_res : pred);
			end
		end
	end

	// drive one command, hold it until the transfer, then maybe leave start low for a random gap
	task automatic issue(cmd_item_t it, logic typed, tracker_result_t res);
		int gap;
		command          <= it.cmd;
		draw_id          <= it.id;
		worker_index     <= it.widx;
		worker_front_pos <= it.fpos;
		worker_back_pos  <= it.bpos;
		read_dependency  <= it.rdep;
		write_dependency <= it.wdep;
		row_typed        <= typed;
		row_res          <= res;
		start            <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		// stretches of back-to-back commands between randomly idling ones
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 6);
			if ($urandom_range(0, 39) == 0)
				calm_left = $urandom_range(10, 30);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every result is back and a full walk would be over
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RING + 2) @(posedge clk);
	endtask

	task automatic program_workers(logic [3:0] wc);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= wc;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		// predictor reset state
		foreach (ring_id[i]) begin
			ring_id[i] = '0;
			ring_live[i] = 1'b0;
			ring_fe_done[i] = 1'b0;
		end
		foreach (wk_front[i]) begin
			wk_front[i] = '0;
			wk_back[i] = '0;
		end
		retired_id = '0;
		issue_id = 32'd1;
		active_workers = 4'd1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset worker count
		for (int i = 0; i < NDIR; i++)
			issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

		// random phases, each behind a worker count write on an idle block
		for (int p = 0; p < NPHASE; p++) begin
			program_workers(wc_plan[p]);
			repeat (PHASE_ITEMS)
				issue(random_command(), 1'b0, '0);
		end

		// let the last results come in, then look for strays
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RING + 4) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
